[hdl/fbc_pkg.sv]
package fbc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int ACC_WIDTH       = 128;

    typedef enum logic [1:0] {
        OP_LOAD_VP    = 2'd0,
        OP_LOAD_WORLD = 2'd1,
        OP_MESH       = 2'd2,
        OP_SPRITE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORLD,
        ST_PLANE,
        ST_CHECK,
        ST_DONE
    } state_t;

    // Control from sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic acc_en;
    } mac_ctl_t;

endpackage

[hdl/fbc_if.sv]
interface fbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [1:0]  row_select;
    logic        item_visible;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic signed [31:0] value_e;
    logic signed [31:0] value_f;

    modport source (output valid, operation, row_select, item_visible,
                    value_a, value_b, value_c, value_d, value_e, value_f,
                    input ready);
    modport sink   (input valid, operation, row_select, item_visible,
                    value_a, value_b, value_c, value_d, value_e, value_f,
                    output ready);
endinterface

interface fbc_out_if;
    logic valid;
    logic ready;
    logic inside_view;
    logic from_sprite;

    modport source (output valid, inside_view, from_sprite, input ready);
    modport sink   (input valid, inside_view, from_sprite, output ready);
endinterface

[hdl/frustum_box_cull.sv]
// Channel   Dir  Payload
// in_ch     in   operation, row_select, item_visible, value_a..value_f
// out_ch    out  inside_view, from_sprite
//
// Loads are taken while idle. Each product runs as issue, 3 limb steps and
// retire. A mesh test runs 18 world products, then per plane 7 products and
// a sign check, or skips a plane with a zero normal; the first failing plane
// ends it. A sprite item skips the world products; a hidden object goes
// straight to the result.
// Reset clears both matrix stores and the sequencer.
// Not ready while a test runs; a result waits in an output register and
// holds the sequencer in its last state only if the next result is done first.
module frustum_box_cull
#(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = fbc_pkg::FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    fbc_in_if.sink      in_ch,
    fbc_out_if.source   out_ch
);

    localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [33:0] HUNDREDTH =
        34'((((64'sd1) <<< FRAC_BITS) + 64'sd50) / 64'sd100);

    fbc_pkg::state_t state_reg, state_next;

    logic [31:0] vp_reg [16];
    logic [31:0] wx_reg [12];

    logic signed [95:0]  wc_reg [3];
    logic signed [95:0]  xe_reg [3];
    logic signed [33:0]  c2_reg [3];
    logic signed [33:0]  e2_reg [3];
    logic                sprite_reg, visible_reg, inside_reg;
    logic                out_valid_reg;
    logic                out_inside_reg, out_sprite_reg;

    // Term counters: world stage i(0..2),t(0..5) / plane p(0..5),t(0..6)
    logic [2:0] p_reg, p_next;
    logic [2:0] t_reg, t_next;
    logic [1:0] i_reg, i_next;
    logic       issued_reg, issued_next;

    fbc_pkg::mac_ctl_t  ctl;
    logic signed [33:0] mac_a;
    logic signed [95:0] mac_b;
    logic               mac_busy;
    logic signed [127:0] acc;

    fbc_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .a     (mac_a),
        .b     (mac_b),
        .busy  (mac_busy),
        .acc   (acc)
    );

    function automatic logic signed [33:0] coord(input logic [31:0] raw);
        logic [CW-1:0] v;
        v = raw[CW-1:0];
        return 34'(signed'(v));
    endfunction

    function automatic logic signed [33:0] abs34(input logic signed [33:0] v);
        return v[33] ? -v : v;
    endfunction

    // Plane normal element c of plane p
    function automatic logic signed [33:0] plane_n(input logic [2:0] p,
                                                   input logic [1:0] c);
        logic signed [33:0] r3;
        logic signed [33:0] rk;
        logic [3:0]         k;
        k  = {2'(p >> 1), 2'b00};
        r3 = coord(vp_reg[{2'd3, c}]);
        rk = coord(vp_reg[k | {2'b00, c}]);
        return p[0] ? r3 - rk : r3 + rk;
    endfunction

    // Plane with no x, y or z component always passes
    logic zero_normal;
    always_comb
    begin
        zero_normal = (plane_n(p_reg, 2'd0) == '0) && (plane_n(p_reg, 2'd1) == '0)
                   && (plane_n(p_reg, 2'd2) == '0);
    end

    logic accept;
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == fbc_pkg::ST_IDLE);

    // Sequencer: next state and operand selection
    always_comb
    begin
        state_next  = state_reg;
        p_next      = p_reg;
        t_next      = t_reg;
        i_next      = i_reg;
        issued_next = issued_reg;
        ctl         = '{clear: 1'b0, acc_en: 1'b0};
        mac_a       = '0;
        mac_b       = '0;
        unique case (state_reg)
            fbc_pkg::ST_IDLE:
            begin
                if (accept && in_ch.operation == fbc_pkg::OP_MESH)
                begin
                    state_next = in_ch.item_visible ? fbc_pkg::ST_WORLD : fbc_pkg::ST_DONE;
                    i_next = 2'd0;
                    t_next = 3'd0;
                    issued_next = 1'b0;
                end
                else if (accept && in_ch.operation == fbc_pkg::OP_SPRITE)
                begin
                    state_next = in_ch.item_visible ? fbc_pkg::ST_PLANE : fbc_pkg::ST_DONE;
                    p_next = 3'd0;
                    t_next = 3'd0;
                    issued_next = 1'b0;
                end
            end
            fbc_pkg::ST_WORLD:
            begin
                // t 0..2: m*c2 into wc[i]; t 3..5: |m|*e2 into xe[i] (direct store)
                if (!mac_busy && !issued_reg)
                begin
                    ctl.acc_en  = 1'b1;
                    ctl.clear   = (t_reg == 3'd0) || (t_reg == 3'd3);
                    issued_next = 1'b1;
                    if (t_reg < 3'd3)
                    begin
                        mac_a = coord(wx_reg[{i_reg, 2'(t_reg)}]);
                        mac_b = 96'(c2_reg[2'(t_reg)]);
                    end
                    else
                    begin
                        mac_a = abs34(coord(wx_reg[{i_reg, 2'(t_reg - 3'd3)}]));
                        mac_b = 96'(e2_reg[2'(t_reg - 3'd3)]);
                    end
                end
                else if (!mac_busy && issued_reg)
                begin
                    issued_next = 1'b0;
                    if (t_reg == 3'd5)
                    begin
                        t_next = 3'd0;
                        if (i_reg == 2'd2)
                        begin
                            state_next = fbc_pkg::ST_PLANE;
                            p_next = 3'd0;
                        end
                        else
                        begin
                            i_next = i_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        t_next = t_reg + 3'd1;
                    end
                end
            end
            fbc_pkg::ST_PLANE:
            begin
                // t 0: n3 * 2^(2F+1); t 1..3: n*wc; t 4..6: |n|*xe
                if (t_reg == 3'd0 && !issued_reg && zero_normal)
                begin
                    if (p_reg == 3'd5)
                    begin
                        state_next = fbc_pkg::ST_DONE;
                    end
                    else
                    begin
                        p_next = p_reg + 3'd1;
                    end
                end
                else if (!mac_busy && !issued_reg)
                begin
                    ctl.acc_en  = 1'b1;
                    ctl.clear   = (t_reg == 3'd0);
                    issued_next = 1'b1;
                    if (t_reg == 3'd0)
                    begin
                        mac_a = plane_n(p_reg, 2'd3);
                        mac_b = 96'sd1 <<< (2 * FRAC_BITS + 1);
                    end
                    else if (t_reg < 3'd4)
                    begin
                        mac_a = plane_n(p_reg, 2'(t_reg - 3'd1));
                        mac_b = wc_reg[2'(t_reg - 3'd1)];
                    end
                    else
                    begin
                        mac_a = abs34(plane_n(p_reg, 2'(t_reg - 3'd4)));
                        mac_b = xe_reg[2'(t_reg - 3'd4)];
                    end
                end
                else if (!mac_busy && issued_reg)
                begin
                    issued_next = 1'b0;
                    if (t_reg == 3'd6)
                    begin
                        state_next = fbc_pkg::ST_CHECK;
                    end
                    else
                    begin
                        t_next = t_reg + 3'd1;
                    end
                end
            end
            fbc_pkg::ST_CHECK:
            begin
                t_next = 3'd0;
                if (acc[127] || p_reg == 3'd5)
                begin
                    state_next = fbc_pkg::ST_DONE;
                end
                else
                begin
                    p_next     = p_reg + 3'd1;
                    state_next = fbc_pkg::ST_PLANE;
                end
            end
            fbc_pkg::ST_DONE:
            begin
                // Wait only while the previous result still sits in the output
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = fbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fbc_pkg::ST_IDLE;
            p_reg          <= '0;
            t_reg          <= '0;
            i_reg          <= '0;
            issued_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_inside_reg <= 1'b0;
            out_sprite_reg <= 1'b0;
            inside_reg     <= 1'b0;
            for (int n = 0; n < 16; n++) vp_reg[n] <= '0;
            for (int n = 0; n < 12; n++) wx_reg[n] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            p_reg      <= p_next;
            t_reg      <= t_next;
            i_reg      <= i_next;
            issued_reg <= issued_next;
            // Row loads
            if (accept && in_ch.operation == fbc_pkg::OP_LOAD_VP)
            begin
                vp_reg[{in_ch.row_select, 2'd0}] <= in_ch.value_a;
                vp_reg[{in_ch.row_select, 2'd1}] <= in_ch.value_b;
                vp_reg[{in_ch.row_select, 2'd2}] <= in_ch.value_c;
                vp_reg[{in_ch.row_select, 2'd3}] <= in_ch.value_d;
            end
            if (accept && in_ch.operation == fbc_pkg::OP_LOAD_WORLD
                && in_ch.row_select != 2'd3)
            begin
                wx_reg[{in_ch.row_select, 2'd0}] <= in_ch.value_a;
                wx_reg[{in_ch.row_select, 2'd1}] <= in_ch.value_b;
                wx_reg[{in_ch.row_select, 2'd2}] <= in_ch.value_c;
                wx_reg[{in_ch.row_select, 2'd3}] <= in_ch.value_d;
            end
            // Result
            if (accept && (in_ch.operation == fbc_pkg::OP_MESH
                           || in_ch.operation == fbc_pkg::OP_SPRITE))
            begin
                inside_reg <= in_ch.item_visible;
            end
            else if (state_reg == fbc_pkg::ST_CHECK && acc[127])
            begin
                inside_reg <= 1'b0;
            end
            // Output register
            if (state_reg == fbc_pkg::ST_DONE && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg  <= 1'b1;
                out_inside_reg <= inside_reg && visible_reg;
                out_sprite_reg <= sprite_reg;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Test setup and world-stage results (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sprite_reg  <= (in_ch.operation == fbc_pkg::OP_SPRITE);
            visible_reg <= in_ch.item_visible;
            c2_reg[0] <= coord(in_ch.value_a) + coord(in_ch.value_d);
            c2_reg[1] <= coord(in_ch.value_b) + coord(in_ch.value_e);
            c2_reg[2] <= coord(in_ch.value_c) + coord(in_ch.value_f);
            e2_reg[0] <= coord(in_ch.value_d) - coord(in_ch.value_a);
            e2_reg[1] <= coord(in_ch.value_e) - coord(in_ch.value_b);
            e2_reg[2] <= coord(in_ch.value_f) - coord(in_ch.value_c);
            if (in_ch.operation == fbc_pkg::OP_SPRITE)
            begin
                wc_reg[0] <= 96'(coord(in_ch.value_a)) <<< (FRAC_BITS + 1);
                wc_reg[1] <= 96'(coord(in_ch.value_b)) <<< (FRAC_BITS + 1);
                wc_reg[2] <= '0;
                xe_reg[0] <= 96'(coord(in_ch.value_c)) <<< FRAC_BITS;
                xe_reg[1] <= 96'(coord(in_ch.value_d)) <<< FRAC_BITS;
                xe_reg[2] <= 96'(HUNDREDTH) <<< (FRAC_BITS + 1);
            end
        end
        else if (state_reg == fbc_pkg::ST_WORLD && !mac_busy && issued_reg)
        begin
            if (t_reg == 3'd2)
            begin
                wc_reg[i_reg] <= acc[95:0]
                    + (96'(coord(wx_reg[{i_reg, 2'd3}])) <<< (FRAC_BITS + 1));
            end
            else if (t_reg == 3'd5)
            begin
                xe_reg[i_reg] <= acc[95:0];
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.inside_view = out_inside_reg;
    assign out_ch.from_sprite = out_sprite_reg;

endmodule

[hdl/fbc_mac.sv]
// Shared multiply-accumulate: acc += a * b, a narrow signed, b wide signed.
// b is split into 32-bit limbs; one 34x34 signed product is taken per cycle step.
module fbc_mac
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  fbc_pkg::mac_ctl_t      ctl,
    input  logic signed [33:0]     a,
    input  logic signed [95:0]     b,
    output logic                   busy,
    output logic signed [127:0]    acc
);

    logic signed [127:0] acc_reg, acc_next;
    logic [1:0]          limb_reg, limb_next;
    logic                run_reg, run_next;
    logic signed [33:0]  a_reg;
    logic signed [95:0]  b_reg;
    logic signed [33:0]  limb_val;
    logic signed [67:0]  prod;
    logic signed [127:0] prod_ext;

    // Limb select: low limbs unsigned, top limb signed
    always_comb
    begin
        unique case (limb_reg)
            2'd0:    limb_val = {2'b00, b_reg[31:0]};
            2'd1:    limb_val = {2'b00, b_reg[63:32]};
            default: limb_val = {{2{b_reg[95]}}, b_reg[95:64]};
        endcase
        prod     = a_reg * limb_val;
        prod_ext = 128'(signed'(prod)) <<< (7'(limb_reg) * 7'd32);
    end

    // Step sequence
    always_comb
    begin
        acc_next  = acc_reg;
        limb_next = limb_reg;
        run_next  = run_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        if (ctl.acc_en)
        begin
            run_next  = 1'b1;
            limb_next = 2'd0;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + prod_ext;
            if (limb_reg == 2'd2)
            begin
                run_next = 1'b0;
            end
            else
            begin
                limb_next = limb_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            limb_reg <= 2'd0;
        end
        else
        begin
            run_reg  <= run_next;
            limb_reg <= limb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctl.acc_en)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    assign busy = run_reg;
    assign acc  = acc_reg;

endmodule
